>>> rtl/socd_pkg.sv
// Shared types, codes and the action builder for the SOCD direction cleaner.
// No dependencies; used by socd_resolve and socd_direction_cleaner.
package socd_pkg;

    localparam logic [1:0] ACT_RELEASE = 2'd0;
    localparam logic [1:0] ACT_PRESS   = 2'd1;
    localparam logic [1:0] ACT_AXIS    = 2'd2;

    localparam logic [1:0] MODE_STANDARD = 2'd0;
    localparam logic [1:0] MODE_NEUTRAL  = 2'd1;
    localparam logic [1:0] MODE_LAST     = 2'd2;

    // direction codes are the low two bits of buttons 12..15
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;

    localparam logic [4:0] BTN_DIR_BASE = 5'd12;
    localparam logic [4:0] BTN_PASS_TOP = 5'd11;
    localparam logic [4:0] BTN_EXTRA    = 5'd16;

    localparam logic signed [7:0] AXIS_NEG  = -8'sd127;
    localparam logic signed [7:0] AXIS_POS  = 8'sd127;
    localparam logic signed [7:0] AXIS_ZERO = 8'sd0;

    typedef struct packed {
        logic [4:0] button;
        logic       pressed;
        logic [1:0] socd_mode;
    } t_in;

    typedef struct packed {
        logic [1:0]        action;
        logic [4:0]        button_index;
        logic              axis_index;
        logic signed [7:0] axis_value;
        logic              last;
    } t_out;

    // One action driving direction d on or off, as d-pad button or stick axis.
    function automatic t_out drive(input logic [1:0] d, input logic on, input logic dpad);
        t_out r;
        r = '0;
        if (dpad) begin
            r.action       = on ? ACT_PRESS : ACT_RELEASE;
            r.button_index = BTN_DIR_BASE + {3'd0, d};
        end else begin
            r.action     = ACT_AXIS;
            r.axis_index = ~d[1];
            if (on) begin
                r.axis_value = d[0] ? AXIS_POS : AXIS_NEG;
            end else begin
                r.axis_value = AXIS_ZERO;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/socd_direction_cleaner.sv
// Top level of the SOCD direction cleaner: held-direction state, output mode
// register and a four-entry result queue. Depends on socd_pkg and socd_resolve.
//
// Usage:
//   Input channel i_valid/o_stall carries one key event (t_in) per transfer.
//   Output channel o_valid/i_stall carries one controller action (t_out) per
//   transfer; an event gives zero, one or two actions, the final one with last.
//   i_cfg_we/i_cfg_wdata write dpad_output (1 = d-pad buttons, 0 = stick axes).
// The actions of an event are written into the result queue at its transfer.
// Throughput: one event per cycle while each gives one action and i_stall is
//   low; the output drains one action per cycle, so two-action events are
//   limited by that drain, which is set by the single read port of the queue.
// o_stall rises when the queue holds three or more actions (room for two is
//   needed to take an event); it comes from r_cnt alone, not from i_stall.
// Reset (synchronous, i_rst_n low): queue empty, all directions released,
//   dpad_output set to 1.
// When the receiver stalls, the head action holds steady and the queue fills
//   until o_stall rises; nothing is dropped.
module socd_direction_cleaner (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  socd_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_stall,
    output socd_pkg::t_out o_result,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata
);
    import socd_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_out            r_fifo [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [3:0]      r_held, n_held;
    logic            r_dpad;

    logic            in_xfer;
    logic            out_xfer;
    logic [1:0]      res_count;
    logic [1:0]      push_n;
    t_out            res0;
    t_out            res1;
    logic [PW-1:0]   wr_ptr_1;

    socd_resolve u_resolve (
        .i_item  (i_item),
        .i_held  (r_held),
        .i_dpad  (r_dpad),
        .o_count (res_count),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_held  (n_held)
    );

    assign o_stall  = (r_cnt > CW'(DEPTH - 2));
    assign in_xfer  = i_valid && !o_stall;
    assign o_valid  = (r_cnt != '0);
    assign out_xfer = o_valid && !i_stall;
    assign o_result = r_fifo[r_rd_ptr];
    assign push_n   = in_xfer ? res_count : 2'd0;
    assign wr_ptr_1 = r_wr_ptr + PW'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(push_n);
        n_rd_ptr = r_rd_ptr + PW'(out_xfer);
        n_cnt    = r_cnt + CW'(push_n) - CW'(out_xfer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_held   <= '0;
            r_dpad   <= 1'b1;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
            if (in_xfer) begin
                r_held <= n_held;
            end
            if (i_cfg_we) begin
                r_dpad <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_fifo[wr_ptr_1] <= res1;
        end
    end

endmodule

>>> rtl/socd_resolve.sv
// Combinational SOCD resolution of one key event against the held directions.
// Depends on socd_pkg.
module socd_resolve (
    input  socd_pkg::t_in  i_item,
    input  logic [3:0]     i_held,
    input  logic           i_dpad,
    output logic [1:0]     o_count,
    output socd_pkg::t_out o_res0,
    output socd_pkg::t_out o_res1,
    output logic [3:0]     o_held
);
    import socd_pkg::*;

    logic [1:0] d;
    logic [1:0] o;
    logic       opp;
    logic       is_pass;
    logic       is_dir;
    t_out       res0;
    t_out       res1;

    assign d       = i_item.button[1:0];
    assign o       = d ^ 2'd1;
    assign opp     = i_held[o];
    assign is_pass = (i_item.button <= BTN_PASS_TOP) || (i_item.button == BTN_EXTRA);
    assign is_dir  = i_item.button inside {[5'd12:5'd15]};

    always_comb begin
        o_count = 2'd0;
        o_held  = i_held;
        res0    = '0;
        res1    = '0;
        if (is_pass) begin
            res0.action       = i_item.pressed ? ACT_PRESS : ACT_RELEASE;
            res0.button_index = i_item.button;
            o_count           = 2'd1;
        end else if (is_dir) begin
            if (i_item.pressed) begin
                o_held[d] = 1'b1;
                if ((i_item.socd_mode == MODE_LAST) ||
                    ((i_item.socd_mode != MODE_NEUTRAL) && (d == DIR_UP))) begin
                    // opposite released first, then this direction pressed
                    if (opp) begin
                        res0    = drive(o, 1'b0, i_dpad);
                        res1    = drive(d, 1'b1, i_dpad);
                        o_count = 2'd2;
                    end else begin
                        res0    = drive(d, 1'b1, i_dpad);
                        o_count = 2'd1;
                    end
                end else if ((i_item.socd_mode != MODE_NEUTRAL) && (d == DIR_DOWN)) begin
                    // standard: up wins, down only when up is clear
                    if (!opp) begin
                        res0    = drive(d, 1'b1, i_dpad);
                        o_count = 2'd1;
                    end
                end else begin
                    res0    = opp ? drive(o, 1'b0, i_dpad) : drive(d, 1'b1, i_dpad);
                    o_count = 2'd1;
                end
            end else begin
                o_held[d] = 1'b0;
                res0      = drive(d, 1'b0, i_dpad);
                if (opp) begin
                    res1    = drive(o, 1'b1, i_dpad);
                    o_count = 2'd2;
                end else begin
                    o_count = 2'd1;
                end
            end
        end
        if (o_count == 2'd2) begin
            res1.last = 1'b1;
        end else begin
            res0.last = 1'b1;
        end
    end

    assign o_res0 = res0;
    assign o_res1 = res1;

endmodule

>>> tb/socd_direction_cleaner_test.sv
// Self-checking testbench for socd_direction_cleaner: key events in, controller actions out,
// checked against an in-bench SOCD resolver under random stalls and gaps on both channels.
// Depends on socd_pkg and the socd_direction_cleaner RTL.
module socd_direction_cleaner_test;
    import socd_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [1:0] DIR_RIGHT  = 2'd3;

    localparam logic [4:0] BTN_UP    = 5'd12;
    localparam logic [4:0] BTN_DOWN  = 5'd13;
    localparam logic [4:0] BTN_LEFT  = 5'd14;
    localparam logic [4:0] BTN_RIGHT = 5'd15;

    localparam int   SETTLE_CYCLES = 4;
    localparam int   HOLD_CYCLES   = 200;
    localparam int   PHASE_EVENTS  = 66;
    localparam t_out NO_ACT        = '0;

    typedef struct {
        bit   dpad;
        t_in  ev;
        int   n_typed;   // -1: take the resolver's answer
        t_out first;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_item;
    logic o_valid;
    logic i_stall;
    t_out o_result;
    logic i_cfg_we;
    logic i_cfg_wdata;

    t_out expected_actions [$];
    int   mismatches  = 0;
    int   holds_asked = 0;
    bit   tx_quiet    = 1'b0;
    bit   rx_quiet    = 1'b0;

    // resolver state
    bit dir_held [4] = '{default: 1'b0};
    bit dpad_mode    = 1'b1;

    t_row script [25] = '{
        '{1'b1, '{5'd0,      1'b1, MODE_STANDARD}, 1, '{ACT_PRESS,   5'd0,  1'b0, AXIS_ZERO, 1'b1}},
        '{1'b1, '{5'd11,     1'b0, MODE_NEUTRAL},  1, '{ACT_RELEASE, 5'd11, 1'b0, AXIS_ZERO, 1'b1}},
        '{1'b1, '{5'd16,     1'b1, MODE_LAST},     1, '{ACT_PRESS,   5'd16, 1'b0, AXIS_ZERO, 1'b1}},
        '{1'b1, '{5'd31,     1'b1, MODE_STANDARD}, 0, NO_ACT},
        '{1'b1, '{5'd17,     1'b0, MODE_SPARE},    0, NO_ACT},
        '{1'b1, '{BTN_UP,    1'b1, MODE_STANDARD}, 1, '{ACT_PRESS,   BTN_UP, 1'b0, AXIS_ZERO, 1'b1}},
        '{1'b1, '{BTN_DOWN,  1'b1, MODE_STANDARD}, -1, NO_ACT},
        '{1'b1, '{BTN_UP,    1'b0, MODE_STANDARD}, -1, NO_ACT},
        '{1'b1, '{BTN_DOWN,  1'b0, MODE_NEUTRAL},  -1, NO_ACT},
        '{1'b1, '{BTN_LEFT,  1'b1, MODE_NEUTRAL},  -1, NO_ACT},
        '{1'b1, '{BTN_RIGHT, 1'b1, MODE_NEUTRAL},  -1, NO_ACT},
        '{1'b1, '{BTN_RIGHT, 1'b0, MODE_NEUTRAL},  -1, NO_ACT},
        '{1'b1, '{BTN_DOWN,  1'b1, MODE_LAST},     -1, NO_ACT},
        '{1'b1, '{BTN_UP,    1'b1, MODE_LAST},     -1, NO_ACT},
        '{1'b1, '{BTN_UP,    1'b0, MODE_SPARE},    -1, NO_ACT},
        '{1'b1, '{BTN_RIGHT, 1'b1, MODE_SPARE},    -1, NO_ACT},
        '{1'b1, '{BTN_LEFT,  1'b0, MODE_LAST},     -1, NO_ACT},
        '{1'b1, '{BTN_DOWN,  1'b0, MODE_STANDARD}, -1, NO_ACT},
        '{1'b0, '{BTN_UP,    1'b1, MODE_STANDARD}, 1, '{ACT_AXIS, 5'd0, 1'b1, AXIS_NEG, 1'b1}},
        '{1'b0, '{BTN_DOWN,  1'b1, MODE_LAST},     -1, NO_ACT},
        '{1'b0, '{BTN_LEFT,  1'b1, MODE_STANDARD}, -1, NO_ACT},
        '{1'b0, '{BTN_RIGHT, 1'b0, MODE_NEUTRAL},  -1, NO_ACT},
        '{1'b0, '{BTN_DOWN,  1'b0, MODE_STANDARD}, -1, NO_ACT},
        '{1'b0, '{5'd3,      1'b0, MODE_SPARE},    1, '{ACT_RELEASE, 5'd3, 1'b0, AXIS_ZERO, 1'b1}},
        '{1'b0, '{5'd30,     1'b0, MODE_LAST},     0, NO_ACT}
    };

    socd_direction_cleaner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_out dir_action(input logic [1:0] d, input logic on);
        t_out a;
        a = '0;
        if (dpad_mode) begin
            a.action       = on ? ACT_PRESS : ACT_RELEASE;
            a.button_index = BTN_UP + 5'(d);
        end else begin
            a.action     = ACT_AXIS;
            a.axis_index = (d == DIR_UP || d == DIR_DOWN);
            if (!on) begin
                a.axis_value = AXIS_ZERO;
            end else if (d == DIR_DOWN || d == DIR_RIGHT) begin
                a.axis_value = AXIS_POS;
            end else begin
                a.axis_value = AXIS_NEG;
            end
        end
        return a;
    endfunction

    // Updates the held flags and returns the actions one event causes.
    function automatic int resolve_event(input t_in ev, output t_out acts [2]);
        logic [1:0] d;
        logic [1:0] o;
        bit         opp;
        int         n;
        n       = 0;
        acts[0] = '0;
        acts[1] = '0;
        if (ev.button <= BTN_PASS_TOP || ev.button == BTN_EXTRA) begin
            acts[0].action       = ev.pressed ? ACT_PRESS : ACT_RELEASE;
            acts[0].button_index = ev.button;
            n = 1;
        end else if (ev.button >= BTN_UP && ev.button <= BTN_RIGHT) begin
            d   = ev.button[1:0];
            o   = d ^ 2'd1;
            opp = dir_held[o];
            if (ev.pressed) begin
                dir_held[d] = 1'b1;
                if (ev.socd_mode == MODE_LAST) begin
                    if (opp) begin
                        acts[n] = dir_action(o, 1'b0); n++;
                    end
                    acts[n] = dir_action(d, 1'b1); n++;
                end else if (!d[1] && ev.socd_mode != MODE_NEUTRAL) begin
                    // standard vertical: up always wins, down only onto a free axis
                    if (d == DIR_UP) begin
                        if (opp) begin
                            acts[n] = dir_action(o, 1'b0); n++;
                        end
                        acts[n] = dir_action(d, 1'b1); n++;
                    end else if (!opp) begin
                        acts[n] = dir_action(d, 1'b1); n++;
                    end
                end else if (opp) begin
                    acts[n] = dir_action(o, 1'b0); n++;
                end else begin
                    acts[n] = dir_action(d, 1'b1); n++;
                end
            end else begin
                dir_held[d] = 1'b0;
                acts[n] = dir_action(d, 1'b0); n++;
                if (opp) begin
                    acts[n] = dir_action(o, 1'b1); n++;
                end
            end
        end
        if (n > 0) begin
            acts[n-1].last = 1'b1;
        end
        return n;
    endfunction

    function automatic t_in random_event();
        t_in ev;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            ev.button = BTN_UP + 5'($urandom_range(0, 3));
        end else if (pick < 84) begin
            ev.button = 5'($urandom_range(0, 11));
        end else if (pick < 90) begin
            ev.button = BTN_EXTRA;
        end else begin
            ev.button = 5'($urandom_range(17, 31));
        end
        ev.pressed   = 1'($urandom_range(0, 1));
        ev.socd_mode = ($urandom_range(0, 99) < 8) ? MODE_SPARE : 2'($urandom_range(0, 2));
        return ev;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic signed [8:0] got,
                               input logic signed [8:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    task automatic send_event(input t_in ev, input int typed_n, input t_out typed_first);
        t_out acts [2];
        int   n;
        int   pick;
        int   gap;
        i_valid <= 1'b1;
        i_item  <= ev;
        do @(posedge i_clk); while (o_stall);
        n = resolve_event(ev, acts);
        if (typed_n < 0) begin
            for (int k = 0; k < n; k++) begin
                expected_actions.push_back(acts[k]);
            end
        end else if (typed_n == 1) begin
            expected_actions.push_back(typed_first);
        end
        pick = $urandom_range(0, 99);
        if (tx_quiet || pick < 50) begin
            gap = 0;
        end else if (pick < 85) begin
            gap = $urandom_range(1, 3);
        end else if (pick < 97) begin
            gap = $urandom_range(4, 10);
        end else begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender off, queue drained, then a settling wait for events that give no action.
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_actions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dpad(input bit v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        dpad_mode  = v;
    endtask

    initial begin : drain_pacing
        int run_left;
        bit run_stall;
        int holds_served;
        run_left     = 0;
        run_stall    = 1'b0;
        holds_served = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_asked != holds_served) begin
                holds_served = holds_asked;
                run_stall    = 1'b1;
                run_left     = HOLD_CYCLES;
            end else if (run_left == 0) begin
                if (rx_quiet) begin
                    run_stall = 1'b0;
                    run_left  = 1;
                end else begin
                    case ($urandom_range(0, 99)) inside
                        [0:54]: begin
                            run_stall = 1'b0;
                            run_left  = $urandom_range(1, 6);
                        end
                        [55:87]: begin
                            run_stall = 1'b1;
                            run_left  = $urandom_range(1, 3);
                        end
                        default: begin
                            run_stall = 1'b1;
                            run_left  = $urandom_range(8, 40);
                        end
                    endcase
                end
            end
            i_stall <= run_stall;
            run_left--;
        end
    end

    always @(posedge i_clk) begin : action_check
        t_out want;
        if (i_rst_n === 1'b1 && o_valid && !i_stall) begin
            if (expected_actions.size() == 0) begin
                note_mismatch($sformatf("unexpected action %h", o_result));
            end else begin
                want = expected_actions.pop_front();
                check_field("action", 9'(o_result.action), 9'(want.action));
                check_field("button_index", 9'(o_result.button_index),
                            9'(want.button_index));
                check_field("axis_index", 9'(o_result.axis_index), 9'(want.axis_index));
                check_field("axis_value", 9'(o_result.axis_value), 9'(want.axis_value));
                check_field("last", 9'(o_result.last), 9'(want.last));
            end
        end
    end

    initial begin : stimulus
        t_in ev;
        int  useful;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_item      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].dpad != dpad_mode) begin
                settle();
                write_dpad(script[i].dpad);
            end
            send_event(script[i].ev, script[i].n_typed, script[i].first);
        end

        // phase 2: receiver holds off while events keep coming; phase 4: no idling
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_dpad(ph % 2 == 1);
            tx_quiet = (ph == 2 || ph == 4);
            rx_quiet = (ph == 4);
            if (ph == 2) begin
                holds_asked++;
            end
            useful = 0;
            while (useful < PHASE_EVENTS) begin
                ev = random_event();
                if (ev.button <= BTN_EXTRA) begin
                    useful++;
                end
                send_event(ev, -1, NO_ACT);
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        settle();

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #20000000;
        $display("timeout with %0d actions outstanding", expected_actions.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
